// ===== sv/lfba_pkg.sv =====
// Shared constants, types and helpers of the lowest free block allocator.
`default_nettype none
package lfba_pkg;

  localparam int BLOCK_COUNT = 4096;
  localparam int WORD_BITS   = 64;
  localparam int MAP_WORDS   = BLOCK_COUNT / WORD_BITS;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int BLK_W       = 16;
  localparam int GRANT_W     = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [WORD_BITS-1:0] map_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the incoming item
    logic find;      // pick the lowest nonempty word from the summary
    logic rd_free;   // read the word addressed by the freed block
    logic rd_alloc;  // read the word picked by the summary search
    logic wr_free;   // set the freed bit and write back
    logic wr_alloc;  // clear the lowest bit, write back, load the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_op;    // op field of the offered item
    logic out_free;  // result register can take a new item this cycle
  } dp_sts_t;

  // Position of the lowest set bit; zero for an all-zero word.
  function automatic logic [BIT_IDX_W-1:0] lowest_one(input map_word_t w);
    map_word_t             iso;
    logic [BIT_IDX_W-1:0]  idx;
    iso = w & (~w + map_word_t'(1));
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ===== sv/lfba_req_if.sv =====
// Request channel: op and block number with valid/ready.
`default_nettype none
interface lfba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lfba_pkg::BLK_W-1:0]  block_number;

  modport source (output valid, output op, output block_number, input ready);
  modport sink   (input valid, input op, input block_number, output ready);
endinterface
`default_nettype wire

// ===== sv/lfba_rsp_if.sv =====
// Result channel: granted block and empty flag with valid/ready.
`default_nettype none
interface lfba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lfba_pkg::GRANT_W-1:0]  granted_block;
  logic                          none_free;

  modport source (output valid, output granted_block, output none_free, input ready);
  modport sink   (input valid, input granted_block, input none_free, output ready);
endinterface
`default_nettype wire

// ===== sv/lowest_free_block_allocator.sv =====
// Top level of the lowest free block allocator.
//
// Keeps 4096 disk blocks as a free bitmap: 64 words of 64 bits in a memory,
// plus a 64-bit summary register with one bit per nonempty word.
// Channels: req_i carries op (0 allocate, 1 free) and block_number; rsp_o
// carries granted_block and none_free, one item per allocate, none per free.
// A free of an already free block changes nothing; a number at or above
// 4096 is dropped.
// Steps: an allocate passes through accept, summary search, word read, then
// bit search with write-back, and its result is registered at write-back; a
// free passes through accept, word read and write-back. One item is in work
// at a time: the next item is accepted only after the last one's write-back,
// since each item does a read-modify-write of the single-port bitmap memory.
// Reset clears the summary register, so every block reads as used; the
// memory itself is not cleared, since a word with its summary bit low is
// taken as all zero. The host frees each usable block after reset.
// A stalled receiver holds the result in its register; a new item is still
// accepted, but the next allocate waits at write-back until the slot frees.
`default_nettype none
module lowest_free_block_allocator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lfba_req_if.sink    req_i,
  lfba_rsp_if.source  rsp_o
);

  lfba_pkg::ctrl_cmd_t cmd;
  lfba_pkg::dp_sts_t   sts;

  // Sequence each item through its memory read and write-back.
  lfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the bitmap, the summary and the result register.
  lfba_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire

// ===== sv/lfba_ctrl.sv =====
// Controller state machine of the allocator.
`default_nettype none
module lfba_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  output logic                      req_ready_o,
  input  wire lfba_pkg::dp_sts_t    sts_i,
  output lfba_pkg::ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRD   = 3'd1;
  localparam logic [2:0] S_FWR   = 3'd2;
  localparam logic [2:0] S_AFIND = 3'd3;
  localparam logic [2:0] S_ARD   = 3'd4;
  localparam logic [2:0] S_AWR   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (sts_i.req_op == lfba_pkg::OP_FREE) ? S_FRD : S_AFIND;
        end
      end
      S_FRD: begin
        cmd_o.rd_free = 1'b1;
        state_d = S_FWR;
      end
      S_FWR: begin
        cmd_o.wr_free = 1'b1;
        state_d = S_IDLE;
      end
      S_AFIND: begin
        cmd_o.find = 1'b1;
        state_d = S_ARD;
      end
      S_ARD: begin
        cmd_o.rd_alloc = 1'b1;
        state_d = S_AWR;
      end
      S_AWR: begin
        // hold until the result register can take the item
        if (sts_i.out_free) begin
          cmd_o.wr_alloc = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lfba_dp.sv =====
// Datapath: bitmap memory, summary register, bit search and result register.
`default_nettype none
module lfba_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lfba_pkg::ctrl_cmd_t cmd_i,
  output lfba_pkg::dp_sts_t        sts_o,
  lfba_req_if.sink                 req_i,
  lfba_rsp_if.source               rsp_o
);

  logic [lfba_pkg::BLK_W-1:0]      blk_q;
  logic [lfba_pkg::MAP_WORDS-1:0]  summary_q;
  logic [lfba_pkg::WORD_IDX_W-1:0] word_q;
  logic                            found_q;
  lfba_pkg::map_word_t             mem_q [lfba_pkg::MAP_WORDS];
  lfba_pkg::map_word_t             rdata_q;
  logic                            out_valid_q;
  logic [lfba_pkg::GRANT_W-1:0]    grant_q;
  logic                            none_q;

  logic [lfba_pkg::WORD_IDX_W-1:0] blk_word;
  logic [lfba_pkg::BIT_IDX_W-1:0]  blk_bit;
  logic                            blk_in_range;
  logic [lfba_pkg::WORD_IDX_W-1:0] raddr;
  logic [lfba_pkg::WORD_IDX_W-1:0] waddr;
  lfba_pkg::map_word_t             wdata;
  logic                            we;
  lfba_pkg::map_word_t             cur_word;
  logic [lfba_pkg::BIT_IDX_W-1:0]  alloc_bit;
  lfba_pkg::map_word_t             alloc_word;
  lfba_pkg::map_word_t             free_word;

  assign blk_word     = blk_q[lfba_pkg::BIT_IDX_W +: lfba_pkg::WORD_IDX_W];
  assign blk_bit      = blk_q[lfba_pkg::BIT_IDX_W-1:0];
  assign blk_in_range = (blk_q < lfba_pkg::BLK_W'(lfba_pkg::BLOCK_COUNT));

  assign sts_o.req_op   = req_i.op;
  assign sts_o.out_free = !out_valid_q || rsp_o.ready;

  // A word whose summary bit is clear holds no free block, written or not.
  assign cur_word   = summary_q[cmd_i.wr_free ? blk_word : word_q] ? rdata_q : '0;
  assign alloc_bit  = lfba_pkg::lowest_one(cur_word);
  assign alloc_word = cur_word & ~(lfba_pkg::map_word_t'(1) << alloc_bit);
  assign free_word  = cur_word | (lfba_pkg::map_word_t'(1) << blk_bit);

  assign raddr = cmd_i.rd_free ? blk_word : word_q;
  assign waddr = cmd_i.wr_free ? blk_word : word_q;
  assign wdata = cmd_i.wr_free ? free_word : alloc_word;
  assign we    = (cmd_i.wr_free && blk_in_range) || (cmd_i.wr_alloc && found_q);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_free || cmd_i.rd_alloc) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q <= req_i.block_number;
    end
    if (cmd_i.find) begin
      word_q  <= lfba_pkg::WORD_IDX_W'(lfba_pkg::lowest_one(summary_q));
      found_q <= |summary_q;
    end
    if (cmd_i.wr_alloc) begin
      grant_q <= found_q ? lfba_pkg::GRANT_W'({word_q, alloc_bit}) : '0;
      none_q  <= !found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      summary_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_free && blk_in_range) begin
        summary_q[blk_word] <= 1'b1;
      end else if (cmd_i.wr_alloc && found_q) begin
        summary_q[word_q] <= |alloc_word;
      end
      if (cmd_i.wr_alloc) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.granted_block = grant_q;
  assign rsp_o.none_free     = none_q;

endmodule
`default_nettype wire
